[rtl/plt_pkg.sv]
// Package of shared constants, types and codes for the positional list table.
package plt_pkg;

   localparam int CAPACITY    = 128;
   localparam int ELEM_BITS   = 8;
   localparam int IDX_BITS    = $clog2(CAPACITY);
   localparam int CNT_BITS    = $clog2(CAPACITY + 1);
   localparam int LEAVES      = 1 << IDX_BITS;

   localparam int CMD_BITS    = 3;
   localparam int POS_BITS    = 8;
   localparam int VALUE_BITS  = 8;
   localparam int OUT_ELEM_BITS = 8;
   localparam int OUT_IDX_BITS  = 7;
   localparam int OUT_LEN_BITS  = 8;
   localparam int CMP_BITS    = ((CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS) + 1;
   localparam int WAIT_BITS   = $clog2(IDX_BITS + 2);
   localparam int WAIT_DONE   = IDX_BITS + 1;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_CLEAR  = 3'd0,
      CMD_INSERT = 3'd1,
      CMD_DELETE = 3'd2,
      CMD_GET    = 3'd3,
      CMD_LOCATE = 3'd4,
      CMD_NEXT   = 3'd5,
      CMD_PRIOR  = 3'd6
   } plt_cmd_type;

   typedef enum logic {
      S_IDLE,
      S_SEARCH
   } plt_state_type;

   typedef struct packed {
      logic                 up;
      logic                 down;
      logic [IDX_BITS-1:0]  pos;
      logic [ELEM_BITS-1:0] value;
   } plt_shift_type;

   typedef struct packed {
      logic                 get;
      logic [IDX_BITS-1:0]  pos;
      logic [ELEM_BITS-1:0] value;
      logic [CNT_BITS-1:0]  count;
   } plt_search_type;

   typedef struct packed {
      logic                 found;
      logic [IDX_BITS-1:0]  idx;
      logic [ELEM_BITS-1:0] data;
   } plt_node_type;

endpackage

[rtl/plt_cell.sv]
// One list cell: holds one element, shifts with its neighbors and flags a search hit.
module plt_cell (
   input  logic                              clock,
   input  logic [plt_pkg::IDX_BITS-1:0]      cell_index,
   input  logic [plt_pkg::ELEM_BITS-1:0]     left_data,
   input  logic [plt_pkg::ELEM_BITS-1:0]     right_data,
   input  plt_pkg::plt_shift_type            shift,
   input  plt_pkg::plt_search_type           search,
   output logic [plt_pkg::ELEM_BITS-1:0]     data_out,
   output plt_pkg::plt_node_type             leaf_out
);

   logic [plt_pkg::ELEM_BITS-1:0] data_ff;
   logic [plt_pkg::ELEM_BITS-1:0] data_in;
   plt_pkg::plt_node_type         leaf_ff;
   plt_pkg::plt_node_type         leaf_in;

   always_comb begin
      priority if (shift.up && (cell_index > shift.pos)) begin
         data_in = left_data;
      end else if (shift.up && (cell_index == shift.pos)) begin
         data_in = shift.value;
      end else if (shift.down && (cell_index >= shift.pos)) begin
         data_in = right_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_comb begin
      leaf_in.found = (plt_pkg::CNT_BITS'(cell_index) < search.count) &&
                      (search.get ? (cell_index == search.pos) : (data_ff == search.value));
      leaf_in.idx   = cell_index;
      leaf_in.data  = data_ff;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      leaf_ff <= leaf_in;
   end

   assign data_out = data_ff;
   assign leaf_out = leaf_ff;

endmodule

[rtl/plt_node.sv]
// Registered node of the first-hit tree: keeps the lower-index hit of its two children.
module plt_node (
   input  logic                  clock,
   input  plt_pkg::plt_node_type left_node,
   input  plt_pkg::plt_node_type right_node,
   output plt_pkg::plt_node_type node_out
);

   plt_pkg::plt_node_type node_ff;
   plt_pkg::plt_node_type node_in;

   always_comb begin
      node_in = left_node.found ? left_node : right_node;
   end

   always_ff @(posedge clock) begin
      node_ff <= node_in;
   end

   assign node_out = node_ff;

endmodule

[rtl/positional_list_table.sv]
// Top level of the positional list table: cell chain, first-hit tree and command control.
//
// Commands arrive on the req_ stream, one word each: command, 1-based position and value.
// Results leave on the rsp_ stream, one word per command: ok, element, index, length
// and empty flag. The list lives in a row of CAPACITY cells; insert and delete move
// every cell at or above the position to its neighbor at once.
// Clear, insert, delete, a get that is out of range and the unused code finish without
// a search: the result is valid in the cycle after the command word is taken.
// Get, locate, next and prior load a search key; every cell flags its hit, and a
// registered tree of IDX_BITS levels picks the lowest hit. Their result is written once
// the hit has passed through the tree, and the next word is taken only after that, so
// a search command must finish before the block takes another command.
// req_tready is high while no search is in flight and the result register is free
// or being emptied, so a new word is taken while the last result is handed over.
// When the receiver stalls, the result word holds and no further command is taken.
// Reset empties the list and drops any pending result; element storage is not cleared.
module positional_list_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // command[2:0], position[10:3], value[18:11], zeros
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // ok[0], element[8:1], index[15:9], length[23:16],
                                   // empty_res[24], zeros
);

   localparam int CAP    = plt_pkg::CAPACITY;
   localparam int LEAVES = plt_pkg::LEAVES;

   logic [plt_pkg::CMD_BITS-1:0]   req_command;
   logic [plt_pkg::POS_BITS-1:0]   req_position;
   logic [plt_pkg::VALUE_BITS-1:0] req_value;

   plt_pkg::plt_state_type             state_ff, state_in;
   logic [plt_pkg::CNT_BITS-1:0]       count_ff, count_in;
   logic [plt_pkg::WAIT_BITS-1:0]      wait_ff, wait_in;
   plt_pkg::plt_cmd_type               cmd_ff, cmd_in;
   logic                               key_get_ff, key_get_in;
   logic [plt_pkg::IDX_BITS-1:0]       key_pos_ff, key_pos_in;
   logic [plt_pkg::ELEM_BITS-1:0]      key_value_ff, key_value_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               ok_ff, ok_in;
   logic [plt_pkg::OUT_ELEM_BITS-1:0]  element_ff, element_in;
   logic [plt_pkg::OUT_IDX_BITS-1:0]   index_ff, index_in;
   logic [plt_pkg::OUT_LEN_BITS-1:0]   length_ff, length_in;
   logic                               empty_ff, empty_in;

   logic                               accept;
   logic                               out_free;
   logic                               insert_ok;
   plt_pkg::plt_shift_type             shift;
   plt_pkg::plt_search_type            search;

   logic [plt_pkg::ELEM_BITS-1:0]      cell_data [CAP];
   plt_pkg::plt_node_type              tree [1:2*LEAVES-1];

   assign req_command  = req_tdata[2:0];
   assign req_position = req_tdata[10:3];
   assign req_value    = req_tdata[18:11];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == plt_pkg::S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;

   assign search.get   = key_get_ff;
   assign search.pos   = key_pos_ff;
   assign search.value = key_value_ff;
   assign search.count = count_ff;

   genvar gi;
   generate
      for (gi = 0; gi < CAP; gi++) begin : g_cell
         logic [plt_pkg::ELEM_BITS-1:0] left_d;
         logic [plt_pkg::ELEM_BITS-1:0] right_d;
         if (gi == 0) begin : g_first
            assign left_d = shift.value;
         end else begin : g_inner_left
            assign left_d = cell_data[gi-1];
         end
         if (gi == CAP - 1) begin : g_last
            assign right_d = cell_data[gi];
         end else begin : g_inner_right
            assign right_d = cell_data[gi+1];
         end
         plt_cell u_cell (
            .clock      (clock),
            .cell_index (plt_pkg::IDX_BITS'(gi)),
            .left_data  (left_d),
            .right_data (right_d),
            .shift      (shift),
            .search     (search),
            .data_out   (cell_data[gi]),
            .leaf_out   (tree[LEAVES+gi])
         );
      end
      for (gi = CAP; gi < LEAVES; gi++) begin : g_pad
         assign tree[LEAVES+gi] = '0;
      end
      for (gi = 1; gi < LEAVES; gi++) begin : g_node
         plt_node u_node (
            .clock      (clock),
            .left_node  (tree[2*gi]),
            .right_node (tree[2*gi+1]),
            .node_out   (tree[gi])
         );
      end
   endgenerate

   always_comb begin
      logic [plt_pkg::CMP_BITS-1:0] pos_w;
      logic [plt_pkg::CMP_BITS-1:0] cnt_w;
      logic [plt_pkg::CMP_BITS-1:0] idx_w;
      logic                         in_range;
      logic                         write_out;

      pos_w    = plt_pkg::CMP_BITS'(req_position);
      cnt_w    = plt_pkg::CMP_BITS'(count_ff);
      idx_w    = plt_pkg::CMP_BITS'(tree[1].idx);
      in_range = (pos_w != '0) && (pos_w <= cnt_w);
      insert_ok = (pos_w != '0) && (pos_w <= cnt_w + 1'b1) &&
                  (cnt_w < plt_pkg::CMP_BITS'(CAP));
      write_out = 1'b0;

      state_in     = state_ff;
      count_in     = count_ff;
      wait_in      = wait_ff;
      cmd_in       = cmd_ff;
      key_get_in   = key_get_ff;
      key_pos_in   = key_pos_ff;
      key_value_in = key_value_ff;
      ok_in        = ok_ff;
      element_in   = element_ff;
      index_in     = index_ff;

      shift.up    = 1'b0;
      shift.down  = 1'b0;
      shift.pos   = plt_pkg::IDX_BITS'(pos_w - 1'b1);
      shift.value = plt_pkg::ELEM_BITS'(req_value);

      unique case (state_ff)
         plt_pkg::S_IDLE: begin
            if (accept) begin
               ok_in      = 1'b0;
               element_in = '0;
               index_in   = '0;
               write_out  = 1'b1;
               cmd_in     = plt_pkg::plt_cmd_type'(req_command);
               key_pos_in   = plt_pkg::IDX_BITS'(pos_w - 1'b1);
               key_value_in = plt_pkg::ELEM_BITS'(req_value);
               unique case (req_command)
                  plt_pkg::CMD_CLEAR: begin
                     count_in = '0;
                     ok_in    = 1'b1;
                  end
                  plt_pkg::CMD_INSERT: begin
                     if (insert_ok) begin
                        shift.up = 1'b1;
                        count_in = count_ff + 1'b1;
                        ok_in    = 1'b1;
                     end
                  end
                  plt_pkg::CMD_DELETE: begin
                     if (in_range) begin
                        shift.down = 1'b1;
                        count_in   = count_ff - 1'b1;
                        ok_in      = 1'b1;
                     end
                  end
                  plt_pkg::CMD_GET: begin
                     if (in_range) begin
                        key_get_in = 1'b1;
                        wait_in    = '0;
                        write_out  = 1'b0;
                        state_in   = plt_pkg::S_SEARCH;
                     end
                  end
                  plt_pkg::CMD_LOCATE, plt_pkg::CMD_NEXT, plt_pkg::CMD_PRIOR: begin
                     key_get_in = 1'b0;
                     wait_in    = '0;
                     write_out  = 1'b0;
                     state_in   = plt_pkg::S_SEARCH;
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         plt_pkg::S_SEARCH: begin
            if (wait_ff != plt_pkg::WAIT_BITS'(plt_pkg::WAIT_DONE)) begin
               wait_in = wait_ff + 1'b1;
            end else if (out_free) begin
               write_out  = 1'b1;
               state_in   = plt_pkg::S_IDLE;
               ok_in      = 1'b0;
               element_in = '0;
               index_in   = '0;
               unique case (cmd_ff)
                  plt_pkg::CMD_GET: begin
                     ok_in      = tree[1].found;
                     element_in = tree[1].found ?
                                  plt_pkg::OUT_ELEM_BITS'(tree[1].data) : '0;
                  end
                  plt_pkg::CMD_LOCATE: begin
                     ok_in    = tree[1].found;
                     index_in = tree[1].found ? plt_pkg::OUT_IDX_BITS'(tree[1].idx) : '0;
                  end
                  plt_pkg::CMD_NEXT: begin
                     if (tree[1].found && ((idx_w + 1'b1) < cnt_w)) begin
                        ok_in    = 1'b1;
                        index_in = plt_pkg::OUT_IDX_BITS'(idx_w + 1'b1);
                     end
                  end
                  plt_pkg::CMD_PRIOR: begin
                     if (tree[1].found && (idx_w != '0)) begin
                        ok_in    = 1'b1;
                        index_in = plt_pkg::OUT_IDX_BITS'(idx_w - 1'b1);
                     end
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            state_in = plt_pkg::S_IDLE;
         end
      endcase

      length_in    = write_out ? plt_pkg::OUT_LEN_BITS'(count_in) : length_ff;
      empty_in     = write_out ? (count_in == '0) : empty_ff;
      rsp_valid_in = write_out ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plt_pkg::S_IDLE;
         count_ff     <= '0;
         wait_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      key_get_ff   <= key_get_in;
      key_pos_ff   <= key_pos_in;
      key_value_ff <= key_value_in;
      ok_ff        <= ok_in;
      element_ff   <= element_in;
      index_ff     <= index_in;
      length_ff    <= length_in;
      empty_ff     <= empty_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, empty_ff, length_ff, index_ff, element_ff, ok_ff};

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= plt_pkg::CNT_BITS'(CAP))
      else $error("element count above capacity");

   a_count_frozen_in_search: assert property (@(posedge clock) disable iff (reset)
      (state_ff == plt_pkg::S_SEARCH) |=> $stable(count_ff))
      else $error("element count changed during a search");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_command == plt_pkg::CMD_INSERT) && insert_ok) |=>
      (count_ff == $past(count_ff) + 1'b1))
      else $error("successful insert did not grow the list");

   a_hit_in_list: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == plt_pkg::S_SEARCH) &&
       (wait_ff == plt_pkg::WAIT_BITS'(plt_pkg::WAIT_DONE)) && tree[1].found) |->
      (plt_pkg::CNT_BITS'(tree[1].idx) < count_ff))
      else $error("search hit beyond the end of the list");
`endif

endmodule

[tb/sv/positional_list_table_tb.sv]
// Self-checking testbench for the positional list table: table of directed words, then random words.
`timescale 1ns / 1ps

module positional_list_table_tb;

   localparam logic [plt_pkg::CMD_BITS-1:0] CMD_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int ITEMS_PER_PHASE = 456;
   localparam int BLOCK_ITEMS     = 300;
   localparam int DRAIN_CYCLES    = 24;

   typedef struct packed {
      logic                              empty;
      logic [plt_pkg::OUT_LEN_BITS-1:0]  length;
      logic [plt_pkg::OUT_IDX_BITS-1:0]  index;
      logic [plt_pkg::OUT_ELEM_BITS-1:0] element;
      logic                              ok;
   } list_result_type;

   typedef struct {
      logic [plt_pkg::CMD_BITS-1:0]   cmd;
      logic [plt_pkg::POS_BITS-1:0]   pos;
      logic [plt_pkg::VALUE_BITS-1:0] val;
      bit                             typed;
      list_result_type                res;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // command[2:0], position[10:3], value[18:11], zeros
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // ok[0], element[8:1], index[15:9], length[23:16], empty_res[24]

   logic [plt_pkg::ELEM_BITS-1:0] list_mem [plt_pkg::CAPACITY];
   int                            list_len = 0;
   list_result_type               expected_q [$];
   stim_row_type                  directed_rows [$];
   int                            fail_count = 0;
   int                            cycle_count = 0;
   int                            send_idle_pct = 0;
   int                            recv_stall_pct = 0;

   positional_list_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   function automatic list_result_type mk_res(logic ok, logic [7:0] element, logic [6:0] index,
                                              logic [7:0] length, logic empty);
      list_result_type r;
      r.ok = ok;
      r.element = element;
      r.index = index;
      r.length = length;
      r.empty = empty;
      return r;
   endfunction

   function automatic stim_row_type mk_row(logic [2:0] cmd, logic [7:0] pos, logic [7:0] val,
                                           bit typed, list_result_type res);
      stim_row_type row;
      row.cmd = cmd;
      row.pos = pos;
      row.val = val;
      row.typed = typed;
      row.res = res;
      return row;
   endfunction

   function automatic list_result_type apply_command(logic [2:0] cmd, logic [7:0] pos,
                                                     logic [7:0] val);
      list_result_type r;
      int n;
      int p;
      int hit;
      int i;
      r = '0;
      n = list_len;
      p = pos;
      hit = n;
      for (i = n - 1; i >= 0; i--)
         if (list_mem[i] == val) hit = i;
      case (cmd)
         plt_pkg::CMD_CLEAR: begin
            list_len = 0;
            r.ok = 1'b1;
         end
         plt_pkg::CMD_INSERT: if (p >= 1 && p <= n + 1 && n < plt_pkg::CAPACITY) begin
            for (i = n; i > p - 1; i--) list_mem[i] = list_mem[i - 1];
            list_mem[p - 1] = val;
            list_len = n + 1;
            r.ok = 1'b1;
         end
         plt_pkg::CMD_DELETE: if (p >= 1 && p <= n) begin
            for (i = p - 1; i + 1 < n; i++) list_mem[i] = list_mem[i + 1];
            list_len = n - 1;
            r.ok = 1'b1;
         end
         plt_pkg::CMD_GET: if (p >= 1 && p <= n) begin
            r.element = list_mem[p - 1];
            r.ok = 1'b1;
         end
         plt_pkg::CMD_LOCATE: if (hit < n) begin
            r.index = 7'(hit);
            r.ok = 1'b1;
         end
         plt_pkg::CMD_NEXT: if (hit + 1 < n) begin
            r.index = 7'(hit + 1);
            r.ok = 1'b1;
         end
         plt_pkg::CMD_PRIOR: if (hit > 0 && hit < n) begin
            r.index = 7'(hit - 1);
            r.ok = 1'b1;
         end
         default: begin
         end
      endcase
      r.length = 8'(list_len);
      r.empty = (list_len == 0);
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   task automatic send_word(input logic [2:0] cmd, input logic [7:0] pos,
                            input logic [7:0] val, input bit typed,
                            input list_result_type res);
      list_result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, val, pos, cmd};
      do @(posedge clock); while (!req_tready);
      r = apply_command(cmd, pos, val);
      expected_q.push_back(typed ? res : r);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_q.size() != 0);
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      list_result_type exp_r;
      list_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = list_result_type'(rsp_tdata[24:0]);
         if (expected_q.size() == 0) begin
            $error("result word %h arrived with nothing expected", rsp_tdata);
            fail_count++;
         end else begin
            exp_r = expected_q.pop_front();
            check_field("ok", 32'(exp_r.ok), 32'(got.ok));
            check_field("element", 32'(exp_r.element), 32'(got.element));
            check_field("index", 32'(exp_r.index), 32'(got.index));
            check_field("length", 32'(exp_r.length), 32'(got.length));
            check_field("empty_res", 32'(exp_r.empty), 32'(got.empty));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      list_result_type none;
      list_result_type empty_fail;
      int target;
      int block_left;
      int r;
      logic [2:0] c;
      logic [7:0] p;
      logic [7:0] v;

      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      none = '0;
      empty_fail = mk_res(1'b0, 8'd0, 7'd0, 8'd0, 1'b1);

      directed_rows = {
         mk_row(plt_pkg::CMD_GET,    8'd1,  8'h00, 1'b1, empty_fail),
         mk_row(plt_pkg::CMD_DELETE, 8'd1,  8'h00, 1'b1, empty_fail),
         mk_row(plt_pkg::CMD_LOCATE, 8'd0,  8'h00, 1'b1, empty_fail),
         mk_row(plt_pkg::CMD_NEXT,   8'd0,  8'hFF, 1'b1, empty_fail),
         mk_row(plt_pkg::CMD_PRIOR,  8'd0,  8'h00, 1'b1, empty_fail),
         mk_row(plt_pkg::CMD_INSERT, 8'd0,  8'hAA, 1'b1, empty_fail),
         mk_row(plt_pkg::CMD_INSERT, 8'd2,  8'hAA, 1'b1, empty_fail),
         mk_row(plt_pkg::CMD_INSERT, 8'd1,  8'h00, 1'b1,
                mk_res(1'b1, 8'd0, 7'd0, 8'd1, 1'b0)),
         mk_row(plt_pkg::CMD_INSERT, 8'd2,  8'hFF, 1'b1,
                mk_res(1'b1, 8'd0, 7'd0, 8'd2, 1'b0)),
         mk_row(plt_pkg::CMD_INSERT, 8'd1,  8'h5A, 1'b0, none),
         mk_row(plt_pkg::CMD_GET,    8'd1,  8'h00, 1'b0, none),
         mk_row(plt_pkg::CMD_GET,    8'd3,  8'hFF, 1'b0, none),
         mk_row(plt_pkg::CMD_GET,    8'd4,  8'h00, 1'b0, none),
         mk_row(plt_pkg::CMD_LOCATE, 8'd0,  8'hFF, 1'b0, none),
         mk_row(plt_pkg::CMD_NEXT,   8'd0,  8'hFF, 1'b0, none),
         mk_row(plt_pkg::CMD_PRIOR,  8'd0,  8'h5A, 1'b0, none),
         mk_row(plt_pkg::CMD_NEXT,   8'd0,  8'h5A, 1'b0, none),
         mk_row(plt_pkg::CMD_PRIOR,  8'd0,  8'hFF, 1'b0, none),
         mk_row(plt_pkg::CMD_LOCATE, 8'd0,  8'h77, 1'b0, none),
         mk_row(CMD_UNUSED,          8'hFF, 8'hFF, 1'b0, none),
         mk_row(plt_pkg::CMD_GET,    8'hFF, 8'h00, 1'b0, none),
         mk_row(plt_pkg::CMD_DELETE, 8'd2,  8'h00, 1'b0, none),
         mk_row(plt_pkg::CMD_DELETE, 8'd3,  8'h00, 1'b0, none),
         mk_row(plt_pkg::CMD_DELETE, 8'd2,  8'h00, 1'b0, none),
         mk_row(plt_pkg::CMD_CLEAR,  8'h80, 8'h81, 1'b1,
                mk_res(1'b1, 8'd0, 7'd0, 8'd0, 1'b1))
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[k])
         send_word(directed_rows[k].cmd, directed_rows[k].pos, directed_rows[k].val,
                   directed_rows[k].typed, directed_rows[k].res);
      drain_results();

      // The first block fills the list to capacity; later blocks aim at random lengths.
      target = plt_pkg::CAPACITY;
      block_left = BLOCK_ITEMS;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         repeat (ITEMS_PER_PHASE) begin
            if (block_left == 0) begin
               block_left = BLOCK_ITEMS;
               r = $urandom_range(99);
               target = (r < 40) ? plt_pkg::CAPACITY :
                        (r < 70) ? $urandom_range(0, 8) :
                        $urandom_range(0, plt_pkg::CAPACITY);
            end
            block_left--;
            r = $urandom_range(99);
            if (r < 2 && target <= 8)
               c = plt_pkg::CMD_CLEAR;
            else if (r < 4)
               c = CMD_UNUSED;
            else begin
               r = $urandom_range(99);
               if (list_len < target)
                  c = (r < 65) ? plt_pkg::CMD_INSERT : (r < 70) ? plt_pkg::CMD_DELETE :
                      3'(plt_pkg::CMD_GET + $urandom_range(0, 3));
               else
                  c = (r < 10) ? plt_pkg::CMD_INSERT : (r < 55) ? plt_pkg::CMD_DELETE :
                      3'(plt_pkg::CMD_GET + $urandom_range(0, 3));
            end

            if ($urandom_range(99) < 12) begin
               case ($urandom_range(0, 3))
                  0: p = 8'd0;
                  1: p = 8'(list_len + 1);
                  2: p = 8'(list_len + 2);
                  default: p = 8'($urandom_range(0, 255));
               endcase
            end else if (c == plt_pkg::CMD_INSERT)
               p = 8'($urandom_range(1, list_len + 1));
            else
               p = (list_len == 0) ? 8'd1 : 8'($urandom_range(1, list_len));

            r = $urandom_range(99);
            if (c inside {plt_pkg::CMD_LOCATE, plt_pkg::CMD_NEXT, plt_pkg::CMD_PRIOR} &&
                list_len > 0 && r < 60)
               v = list_mem[$urandom_range(0, list_len - 1)];
            else if (r < 70)
               v = 8'($urandom_range(0, 15));
            else if (r < 80)
               v = (r < 75) ? 8'h00 : 8'hFF;
            else
               v = 8'($urandom_range(0, 255));

            send_word(c, p, v, 1'b0, none);
         end
         drain_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

[filelist.f]
rtl/plt_pkg.sv
rtl/plt_cell.sv
rtl/plt_node.sv
rtl/positional_list_table.sv
tb/sv/positional_list_table_tb.sv
